FILE: rtl/core/assert_macros.svh
// Assertion shorthands used by the checker file.
// Standalone header; needs nothing else.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while in reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

FILE: rtl/core/hrba_pkg.sv
// Shared types and constants of the heart rate beat averager.
// No dependencies.
`timescale 1ns / 1ps

package hrba_pkg;

   localparam int DEF_RATE_SLOTS = 4;

   localparam int IR_W    = 18;
   localparam int TIME_W  = 32;
   localparam int RATE_W  = 16;
   localparam int MINB_W  = 8;
   localparam int MAXB_W  = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 18;

   // serial divider: dividend and divisor widths, one quotient bit per cycle
   localparam int DIV_N_W   = 24;
   localparam int DIV_D_W   = 32;
   localparam int DIV_CNT_W = $clog2(DIV_N_W);

   // range test products: 17-bit clamped interval times 9-bit bpm bound
   localparam int IVL_W  = 17;
   localparam int PROD_W = IVL_W + MAXB_W;

   localparam logic [DIV_N_W-1:0] RATE_NUM   = 24'd15360000;
   localparam logic [PROD_W-1:0]  BPM_NUM    = 26'd60000;
   localparam logic [IVL_W-1:0]   IVL_CLAMP  = 17'h10000;

   localparam logic [IR_W-1:0]   RST_THRESHOLD = 18'd50000;
   localparam logic [MINB_W-1:0] RST_MIN_BPM   = 8'd20;
   localparam logic [MAXB_W-1:0] RST_MAX_BPM   = 9'd255;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_BPM   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_BPM   = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIV_RATE,
      ST_SUM,
      ST_DIV_AVG,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic               start;
      logic [DIV_N_W-1:0] dividend;
      logic [DIV_D_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic               done;
      logic [DIV_N_W-1:0] quotient;
   } div_rsp_type;

endpackage

FILE: rtl/core/hrba_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses hrba_pkg for widths and the request/response structs.
`timescale 1ns / 1ps

module hrba_sdiv (
   input  logic                 clock,
   input  logic                 reset,
   input  hrba_pkg::div_req_type div_req,
   output hrba_pkg::div_rsp_type div_rsp
);

   logic [hrba_pkg::DIV_D_W-1:0]   rem_ff, rem_in;
   logic [hrba_pkg::DIV_N_W-1:0]   quo_ff, quo_in;
   logic [hrba_pkg::DIV_D_W-1:0]   dvs_ff, dvs_in;
   logic [hrba_pkg::DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [hrba_pkg::DIV_D_W:0]     shifted;
   logic [hrba_pkg::DIV_D_W+1:0]   diff;

   assign shifted = {rem_ff, quo_ff[hrba_pkg::DIV_N_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, dvs_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (diff[hrba_pkg::DIV_D_W+1]) begin
            rem_in = shifted[hrba_pkg::DIV_D_W-1:0];
            quo_in = {quo_ff[hrba_pkg::DIV_N_W-2:0], 1'b0};
         end else begin
            rem_in = diff[hrba_pkg::DIV_D_W-1:0];
            quo_in = {quo_ff[hrba_pkg::DIV_N_W-2:0], 1'b1};
         end
         cnt_in = cnt_ff + hrba_pkg::DIV_CNT_W'(1);
         if (cnt_ff == hrba_pkg::DIV_CNT_W'(hrba_pkg::DIV_N_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

FILE: rtl/core/heart_rate_beat_averager_top.sv
// Heart rate beat averager: beat intervals to Q8.8 BPM, averaged over a ring of rates.
// Uses hrba_pkg and hrba_sdiv (shared bit-serial divider).
// One item is worked on at a time. An item with no beat, a first beat, a zero interval or
// an absent finger goes from evaluation straight to the result. A beat that yields a rate
// uses the shared bit-serial divider for the rate; an out-of-range rate then goes to the
// result, while an in-range rate enters the ring, the filled slots are summed and the
// divider forms their mean. The range products are formed bit-serially while the rate
// divide runs. A finished result waits in the output register while the next item is
// accepted; a second result stalls the block until the first is taken.
`timescale 1ns / 1ps

module heart_rate_beat_averager_top #(
   parameter int RATE_SLOTS = hrba_pkg::DEF_RATE_SLOTS
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [hrba_pkg::IR_W-1:0]        req_ir_sample,
   input  logic                             req_beat,
   input  logic [hrba_pkg::TIME_W-1:0]      req_time_ms,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_present,
   output logic [hrba_pkg::RATE_W-1:0]      rsp_avg_bpm,
   output logic [hrba_pkg::RATE_W-1:0]      rsp_beat_bpm,
   output logic                             rsp_accepted,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hrba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hrba_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int IDX_W = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1;
   localparam int CNT_W = $clog2(RATE_SLOTS + 1);
   localparam int SUM_W = hrba_pkg::RATE_W + CNT_W;

   hrba_pkg::state_type state_ff, state_in;

   logic [hrba_pkg::IR_W-1:0]   thr_ff, thr_in;
   logic [hrba_pkg::MINB_W-1:0] minb_ff, minb_in;
   logic [hrba_pkg::MAXB_W-1:0] maxb_ff, maxb_in;

   logic                          present_ff, present_in;
   logic                          beat_ff, beat_in;
   logic [hrba_pkg::TIME_W-1:0]   time_ff, time_in;

   logic [hrba_pkg::RATE_W-1:0]   slots_ff [RATE_SLOTS];
   logic [IDX_W-1:0]              wr_ff, wr_in;
   logic [CNT_W-1:0]              filled_ff, filled_in;
   logic [hrba_pkg::TIME_W-1:0]   last_ff, last_in;
   logic                          seen_ff, seen_in;
   logic [hrba_pkg::RATE_W-1:0]   avg_ff, avg_in;
   logic [hrba_pkg::RATE_W-1:0]   inst_ff, inst_in;
   logic                          accflag_ff, accflag_in;

   logic [hrba_pkg::PROD_W-1:0]   mcand_ff, mcand_in;
   logic [hrba_pkg::MAXB_W-1:0]   minsh_ff, minsh_in;
   logic [hrba_pkg::MAXB_W-1:0]   maxsh_ff, maxsh_in;
   logic [hrba_pkg::PROD_W-1:0]   minacc_ff, minacc_in;
   logic [hrba_pkg::PROD_W-1:0]   maxacc_ff, maxacc_in;

   logic [SUM_W-1:0]              sum_ff, sum_in;
   logic [IDX_W-1:0]              k_ff, k_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_present_ff, rsp_present_in;
   logic [hrba_pkg::RATE_W-1:0]   rsp_avg_ff, rsp_avg_in;
   logic [hrba_pkg::RATE_W-1:0]   rsp_beat_ff, rsp_beat_in;
   logic                          rsp_acc_ff, rsp_acc_in;

   hrba_pkg::div_req_type         div_req;
   hrba_pkg::div_rsp_type         div_rsp;

   logic [hrba_pkg::TIME_W-1:0]   delta;
   logic [hrba_pkg::IVL_W-1:0]    ivl;
   logic                          eval_div;
   logic [hrba_pkg::RATE_W-1:0]   inst_calc;
   logic                          in_range;
   logic [SUM_W-1:0]              sum_next;
   logic                          last_k;
   logic                          emit_ok;
   logic                          slot_we;

   assign delta     = time_ff - last_ff;
   assign ivl       = (|delta[hrba_pkg::TIME_W-1:hrba_pkg::IVL_W-1]) ? hrba_pkg::IVL_CLAMP
                      : {1'b0, delta[hrba_pkg::IVL_W-2:0]};
   assign eval_div  = present_ff && beat_ff && seen_ff && (delta != '0);
   assign inst_calc = (|div_rsp.quotient[hrba_pkg::DIV_N_W-1:hrba_pkg::RATE_W]) ? '1
                      : div_rsp.quotient[hrba_pkg::RATE_W-1:0];
   assign in_range  = (minacc_ff < hrba_pkg::BPM_NUM) && (maxacc_ff > hrba_pkg::BPM_NUM);
   assign sum_next  = sum_ff + SUM_W'(slots_ff[k_ff]);
   assign last_k    = (CNT_W'(k_ff) + CNT_W'(1)) == filled_ff;

   hrba_sdiv u_sdiv (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         hrba_pkg::ST_IDLE:     if (req_valid) state_in = hrba_pkg::ST_EVAL;
         hrba_pkg::ST_EVAL:     state_in = eval_div ? hrba_pkg::ST_DIV_RATE : hrba_pkg::ST_EMIT;
         hrba_pkg::ST_DIV_RATE: begin
            if (div_rsp.done) state_in = in_range ? hrba_pkg::ST_SUM : hrba_pkg::ST_EMIT;
         end
         hrba_pkg::ST_SUM:      if (last_k) state_in = hrba_pkg::ST_DIV_AVG;
         hrba_pkg::ST_DIV_AVG:  if (div_rsp.done) state_in = hrba_pkg::ST_EMIT;
         hrba_pkg::ST_EMIT:     if (emit_ok) state_in = hrba_pkg::ST_IDLE;
         default:               state_in = hrba_pkg::ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready        = 1'b0;
      emit_ok          = 1'b0;
      slot_we          = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = hrba_pkg::RATE_NUM;
      div_req.divisor  = delta;
      unique case (state_ff)
         hrba_pkg::ST_IDLE:     req_ready = 1'b1;
         hrba_pkg::ST_EVAL:     div_req.start = eval_div;
         hrba_pkg::ST_DIV_RATE: slot_we = div_rsp.done && in_range;
         hrba_pkg::ST_SUM: begin
            div_req.start    = last_k;
            div_req.dividend = hrba_pkg::DIV_N_W'(sum_next);
            div_req.divisor  = hrba_pkg::DIV_D_W'(filled_ff);
         end
         hrba_pkg::ST_DIV_AVG:  ;
         hrba_pkg::ST_EMIT:     emit_ok = !rsp_valid_ff || rsp_ready;
         default:               ;
      endcase
   end

   // configuration
   always_comb begin
      thr_in  = thr_ff;
      minb_in = minb_ff;
      maxb_in = maxb_ff;
      if (csr_valid) begin
         unique case (csr_index)
            hrba_pkg::CSR_THRESHOLD: thr_in  = csr_data;
            hrba_pkg::CSR_MIN_BPM:   minb_in = csr_data[hrba_pkg::MINB_W-1:0];
            hrba_pkg::CSR_MAX_BPM:   maxb_in = csr_data[hrba_pkg::MAXB_W-1:0];
            default:                 ;
         endcase
      end
   end

   // datapath
   always_comb begin
      present_in = present_ff;
      beat_in    = beat_ff;
      time_in    = time_ff;
      wr_in      = wr_ff;
      filled_in  = filled_ff;
      last_in    = last_ff;
      seen_in    = seen_ff;
      avg_in     = avg_ff;
      inst_in    = inst_ff;
      accflag_in = accflag_ff;
      sum_in     = sum_ff;
      k_in       = k_ff;
      mcand_in   = mcand_ff << 1;
      minsh_in   = minsh_ff >> 1;
      maxsh_in   = maxsh_ff >> 1;
      minacc_in  = minsh_ff[0] ? minacc_ff + mcand_ff : minacc_ff;
      maxacc_in  = maxsh_ff[0] ? maxacc_ff + mcand_ff : maxacc_ff;

      if (state_ff == hrba_pkg::ST_IDLE && req_valid) begin
         present_in = req_ir_sample > thr_ff;
         beat_in    = req_beat;
         time_in    = req_time_ms;
      end

      if (state_ff == hrba_pkg::ST_EVAL) begin
         accflag_in = 1'b0;
         mcand_in   = hrba_pkg::PROD_W'(ivl);
         minsh_in   = hrba_pkg::MAXB_W'(minb_ff);
         maxsh_in   = maxb_ff;
         minacc_in  = '0;
         maxacc_in  = '0;
         if (!present_ff) begin
            wr_in     = '0;
            filled_in = '0;
            last_in   = '0;
            seen_in   = 1'b0;
            avg_in    = '0;
            inst_in   = '0;
         end else if (beat_ff) begin
            seen_in = 1'b1;
            last_in = time_ff;
         end
      end

      if (state_ff == hrba_pkg::ST_DIV_RATE && div_rsp.done) begin
         inst_in = inst_calc;
         if (in_range) begin
            wr_in      = (wr_ff == IDX_W'(RATE_SLOTS - 1)) ? '0 : wr_ff + IDX_W'(1);
            filled_in  = (filled_ff == CNT_W'(RATE_SLOTS)) ? filled_ff
                         : filled_ff + CNT_W'(1);
            accflag_in = 1'b1;
            sum_in     = '0;
            k_in       = '0;
         end
      end

      if (state_ff == hrba_pkg::ST_SUM) begin
         sum_in = sum_next;
         k_in   = k_ff + IDX_W'(1);
      end

      if (state_ff == hrba_pkg::ST_DIV_AVG && div_rsp.done) begin
         avg_in = div_rsp.quotient[hrba_pkg::RATE_W-1:0];
      end
   end

   // result register
   always_comb begin
      rsp_valid_in   = rsp_valid_ff && !rsp_ready;
      rsp_present_in = rsp_present_ff;
      rsp_avg_in     = rsp_avg_ff;
      rsp_beat_in    = rsp_beat_ff;
      rsp_acc_in     = rsp_acc_ff;
      if (emit_ok) begin
         rsp_valid_in   = 1'b1;
         rsp_present_in = present_ff;
         rsp_avg_in     = avg_ff;
         rsp_beat_in    = inst_ff;
         rsp_acc_in     = accflag_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= hrba_pkg::ST_IDLE;
         thr_ff       <= hrba_pkg::RST_THRESHOLD;
         minb_ff      <= hrba_pkg::RST_MIN_BPM;
         maxb_ff      <= hrba_pkg::RST_MAX_BPM;
         wr_ff        <= '0;
         filled_ff    <= '0;
         last_ff      <= '0;
         seen_ff      <= 1'b0;
         avg_ff       <= '0;
         inst_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         thr_ff       <= thr_in;
         minb_ff      <= minb_in;
         maxb_ff      <= maxb_in;
         wr_ff        <= wr_in;
         filled_ff    <= filled_in;
         last_ff      <= last_in;
         seen_ff      <= seen_in;
         avg_ff       <= avg_in;
         inst_ff      <= inst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      present_ff     <= present_in;
      beat_ff        <= beat_in;
      time_ff        <= time_in;
      accflag_ff     <= accflag_in;
      mcand_ff       <= mcand_in;
      minsh_ff       <= minsh_in;
      maxsh_ff       <= maxsh_in;
      minacc_ff      <= minacc_in;
      maxacc_ff      <= maxacc_in;
      sum_ff         <= sum_in;
      k_ff           <= k_in;
      rsp_present_ff <= rsp_present_in;
      rsp_avg_ff     <= rsp_avg_in;
      rsp_beat_ff    <= rsp_beat_in;
      rsp_acc_ff     <= rsp_acc_in;
      if (slot_we) begin
         slots_ff[wr_ff] <= inst_calc;
      end
   end

   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_present  = rsp_present_ff;
   assign rsp_avg_bpm  = rsp_avg_ff;
   assign rsp_beat_bpm = rsp_beat_ff;
   assign rsp_accepted = rsp_acc_ff;

endmodule

FILE: rtl/core/hrba_checker.sv
// Port-level checks for heart_rate_beat_averager_top, bound to it below.
// Uses hrba_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module hrba_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_valid,
   input logic                             req_ready,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input logic                             rsp_present,
   input logic [hrba_pkg::RATE_W-1:0]      rsp_avg_bpm,
   input logic [hrba_pkg::RATE_W-1:0]      rsp_beat_bpm,
   input logic                             rsp_accepted
);

   logic rsp_zero;

   assign rsp_zero = (rsp_avg_bpm == '0) && (rsp_beat_bpm == '0) && !rsp_accepted;

   // result item held until taken
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // absent finger reports zeros
   `ASSERT_IMPLIES(a_absent_zero, clock, reset, rsp_valid && !rsp_present, rsp_zero)

   // a rate only enters the ring with a finger present
   `ASSERT_IMPLIES(a_acc_present, clock, reset, rsp_valid && rsp_accepted, rsp_present)

   // one item in work at a time
   `ASSERT_NEXT(a_one_item, clock, reset, req_valid && req_ready, !req_ready)

endmodule

bind heart_rate_beat_averager_top hrba_checker u_hrba_checker (.*);
